// ----- hw/rtl/dts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline timer scheduler package
// Shared constants, codes and the request record passed from front to back.
// ----------------------------------------------------------------------------
package dts_pkg;

    localparam int TIMERS_DEF    = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int ID_W          = 4;
    localparam int IN_TIME_W     = 32;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_STOP    = 2'd1,
        CMD_PROCESS = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_OK      = 2'd0,
        KIND_INVALID = 2'd1,
        KIND_EXPIRED = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // Classified request: the front resolves range checks up front.
    typedef struct packed {
        cmd_t            cmd;
        logic            id_ok;
        logic [ID_W-1:0] id;
        logic [IN_TIME_W-1:0] delay;
        logic [IN_TIME_W-1:0] period;
        logic [IN_TIME_W-1:0] now;
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIRE,
        ST_EMIT,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/dts_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline timer scheduler front end
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module dts_front
    import dts_pkg::*;
#(
    parameter int TIMERS = TIMERS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_cmd,
    input  logic [ID_W-1:0] in_id,
    input  logic [IN_TIME_W-1:0] in_delay,
    input  logic [IN_TIME_W-1:0] in_period,
    input  logic [IN_TIME_W-1:0] in_now,
    output logic        q_valid,
    input  logic        q_pop,
    output req_t        q_req
);

    req_t       mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    req_t       in_req;
    logic       push;

    always_comb
    begin
        in_req.cmd    = cmd_t'(in_cmd);
        in_req.id_ok  = ({28'd0, in_id} < 32'(TIMERS));
        in_req.id     = in_id;
        in_req.delay  = in_delay;
        in_req.period = in_period;
        in_req.now    = in_now;
    end

    assign in_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

// ----- hw/rtl/dts_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline timer scheduler back end
// Owns the timer bank and runs commands; expiries use a sequential scan.
// ----------------------------------------------------------------------------
module dts_back
    import dts_pkg::*;
#(
    parameter int TIMERS    = TIMERS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_pop,
    input  req_t        q_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_kind,
    output logic [ID_W-1:0] out_id,
    output logic        out_rearmed,
    output logic        out_last
);

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = $clog2(TIMERS + 1);

    logic [TIME_BITS-1:0] deadline_reg [TIMERS];
    logic [TIME_BITS-1:0] period_reg   [TIMERS];
    logic [TIMERS-1:0]    armed_reg;
    logic [TIMERS-1:0]    due_reg;
    logic [TIME_BITS-1:0] now_reg;

    state_t               state_reg, state_next;
    logic [CW-1:0]        scan_reg;
    logic [IW-1:0]        idx;
    logic                 best_ok_reg;
    logic [IW-1:0]        best_reg;
    logic [TIME_BITS-1:0] best_dl_reg;

    logic                 ov_reg;
    logic [1:0]           okind_reg;
    logic [ID_W-1:0]      oid_reg;
    logic                 orearm_reg;
    logic                 olast_reg;

    logic [TIME_BITS-1:0] delay_t, period_t, now_t, cur_dl, cur_pd;
    logic [TIME_BITS:0]   start_sum, rearm_sum;
    logic                 slot_free;
    logic                 emit;
    logic                 ok_cmd;

    assign idx       = scan_reg[IW-1:0];
    assign delay_t   = TIME_BITS'(q_req.delay);
    assign period_t  = TIME_BITS'(q_req.period);
    assign now_t     = TIME_BITS'(q_req.now);
    assign cur_dl    = deadline_reg[idx];
    assign cur_pd    = period_reg[best_reg];
    assign start_sum = {1'b0, now_reg} + {1'b0, delay_t};
    assign rearm_sum = {1'b0, now_t} + {1'b0, cur_pd};
    assign slot_free = !ov_reg || out_ready;

    // A result is loaded into the output register this cycle.
    assign emit = slot_free && ((state_reg == ST_IDLE && q_valid
                                 && q_req.cmd != CMD_PROCESS)
                                || state_reg == ST_EMIT);

    // Start of a valid timer, or stop of an armed one, answers ok.
    assign ok_cmd = q_req.id_ok && ((q_req.cmd == CMD_START)
                                    || (q_req.cmd == CMD_STOP
                                        && armed_reg[q_req.id[IW-1:0]]));

    assign out_valid   = ov_reg;
    assign out_kind    = okind_reg;
    assign out_id      = oid_reg;
    assign out_rearmed = orearm_reg;
    assign out_last    = olast_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    state_next = (q_req.cmd == CMD_PROCESS) ? ST_SCAN : ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == CW'(TIMERS - 1))
                begin
                    state_next = ST_FIRE;
                end
            end
            ST_FIRE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = (best_ok_reg && due_reg != '0) ? ST_SCAN : ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Pop once a command finishes.
    always_comb
    begin
        q_pop = 1'b0;
        case (state_reg)
            ST_IDLE: q_pop = q_valid && slot_free && (q_req.cmd != CMD_PROCESS);
            ST_DONE: q_pop = 1'b1;
            default: q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            armed_reg <= '0;
            now_reg   <= '0;
            ov_reg    <= 1'b0;
            scan_reg  <= '0;
            due_reg   <= '0;
            best_ok_reg <= 1'b0;
            best_reg  <= '0;
            best_dl_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid && slot_free)
                    begin
                        if (q_req.cmd == CMD_PROCESS)
                        begin
                            now_reg     <= now_t;
                            scan_reg    <= '0;
                            best_ok_reg <= 1'b0;
                            for (int i = 0; i < TIMERS; i++)
                            begin
                                due_reg[i] <= armed_reg[i] && (deadline_reg[i] <= now_t);
                            end
                        end
                        else
                        begin
                            oid_reg    <= q_req.id;
                            orearm_reg <= 1'b0;
                            olast_reg  <= 1'b1;
                            okind_reg  <= ok_cmd ? KIND_OK : KIND_INVALID;
                            if (ok_cmd)
                            begin
                                armed_reg[q_req.id[IW-1:0]] <= (q_req.cmd == CMD_START);
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    scan_reg <= scan_reg + 1'b1;
                    if (due_reg[idx] && (!best_ok_reg || cur_dl < best_dl_reg))
                    begin
                        best_ok_reg <= 1'b1;
                        best_reg    <= idx;
                        best_dl_reg <= cur_dl;
                    end
                end
                ST_FIRE:
                begin
                    if (best_ok_reg)
                    begin
                        due_reg[best_reg] <= 1'b0;
                        if (cur_pd == '0)
                        begin
                            armed_reg[best_reg] <= 1'b0;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        oid_reg    <= best_ok_reg ? ID_W'(best_reg) : '0;
                        okind_reg  <= best_ok_reg ? KIND_EXPIRED : KIND_NONE;
                        orearm_reg <= best_ok_reg && (cur_pd != '0);
                        olast_reg  <= !best_ok_reg || (due_reg == '0);
                        if (best_ok_reg && due_reg != '0)
                        begin
                            scan_reg    <= '0;
                            best_ok_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Timer bank payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && slot_free && q_req.cmd == CMD_START
            && q_req.id_ok)
        begin
            deadline_reg[q_req.id[IW-1:0]] <= start_sum[TIME_BITS] ? '1
                                               : start_sum[TIME_BITS-1:0];
            period_reg[q_req.id[IW-1:0]]   <= period_t;
        end
        else if (state_reg == ST_FIRE && best_ok_reg && cur_pd != '0)
        begin
            deadline_reg[best_reg] <= rearm_sum[TIME_BITS] ? '1 : rearm_sum[TIME_BITS-1:0];
        end
    end

endmodule

// ----- hw/rtl/deadline_timer_scheduler_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline timer scheduler top level
// Bank of timers with start, stop and expiry processing.
// ----------------------------------------------------------------------------
// Channel  | Direction | Payload
// s_axis   | in        | tdata: command, timer_id, delay, period, now
// m_axis   | out       | tdata: kind, expired_id, rearmed; tlast: last
//
// An accepted request is registered in the queue and reaches the back end
// through it. Start, stop and unused requests finish in the idle state. A
// process request starts a scan, then per expired timer (once if none)
// scans all TIMERS slots, retires the earliest due timer and emits a result,
// then pops the request; each emit waits out output stalls.
// Reset clears all armed flags and the current time; the back end stalls
// only on the output register, the two-entry queue absorbs input bursts.
// ----------------------------------------------------------------------------
module deadline_timer_scheduler_top
    import dts_pkg::*;
#(
    parameter int TIMERS    = TIMERS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[1:0], timer_id[5:2], delay[37:6], period[69:38], now[101:70]
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // kind[1:0], expired_id[5:2], rearmed[6]
    output logic [7:0]   m_axis_tdata,
    output logic         m_axis_tlast
);

    logic q_valid, q_pop;
    req_t q_req;
    logic [1:0] kind;
    logic [ID_W-1:0] eid;
    logic rearmed;

    dts_front #(.TIMERS(TIMERS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_cmd(s_axis_tdata[1:0]), .in_id(s_axis_tdata[5:2]),
        .in_delay(s_axis_tdata[37:6]), .in_period(s_axis_tdata[69:38]),
        .in_now(s_axis_tdata[101:70]),
        .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
    );

    dts_back #(.TIMERS(TIMERS), .TIME_BITS(TIME_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_kind(kind), .out_id(eid), .out_rearmed(rearmed),
        .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, rearmed, eid, kind};

    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[103:102];

endmodule
